[rtl/core/eaba_pkg.sv]
// Package for the event-aligned block averager: codes, state type and the
// request and response records of the shared divide and square-root unit.
// Depends on nothing; the top level and eaba_calc refer to it by scoped names.
`timescale 1ns / 1ps

package eaba_pkg;

    localparam int unsigned MAX_SAMPLES = 65536;
    localparam int unsigned MAX_BLOCK   = 64;

    localparam int unsigned CALC_NUM_W = 76;
    localparam int unsigned CALC_DEN_W = 40;

    // Standard deviation used when the baseline holds a single sample (1.1).
    localparam logic [31:0] SD_ONE_POINT_ONE = 32'd72090;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_EVENT = 2'd1;
    localparam logic [1:0] OP_EMIT  = 2'd2;

    localparam logic [2:0] REG_PRE_COUNT        = 3'd0;
    localparam logic [2:0] REG_POST_COUNT       = 3'd1;
    localparam logic [2:0] REG_BASELINE_SPAN    = 3'd2;
    localparam logic [2:0] REG_BASELINE_EXCLUDE = 3'd3;
    localparam logic [2:0] REG_NORM_MODE        = 3'd4;
    localparam logic [2:0] REG_OUTPUT_MODE      = 3'd5;
    localparam logic [2:0] REG_NEGATE_INPUT     = 3'd6;

    localparam logic [2:0] NORM_NONE        = 3'd0;
    localparam logic [2:0] NORM_MINUS_START = 3'd1;
    localparam logic [2:0] NORM_BASE_MEAN   = 3'd2;
    localparam logic [2:0] NORM_ZSCORE      = 3'd3;
    localparam logic [2:0] NORM_DIV_MEAN    = 3'd4;

    localparam logic [1:0] ST_VALUE     = 2'd0;
    localparam logic [1:0] ST_EARLY     = 2'd1;
    localparam logic [1:0] ST_BEYOND    = 2'd2;
    localparam logic [1:0] ST_NO_BLOCKS = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SKIP,
        S_SCAN,
        S_VAR1,
        S_VAR2,
        S_VDIV,
        S_SQRT,
        S_DEN,
        S_XRD,
        S_XWAIT,
        S_XNUM,
        S_DPREP,
        S_DCHK,
        S_DWAIT,
        S_PUT,
        S_ACC_WR,
        S_OUT,
        S_EM_RD,
        S_EM_WAIT
    } t_state;

    typedef enum logic [1:0] {
        CALC_DIV_LONG,
        CALC_DIV_SHORT,
        CALC_SQRT
    } t_calc_op;

    typedef struct packed {
        logic                  start;
        t_calc_op              op;
        logic [CALC_NUM_W-1:0] num;
        logic [CALC_DEN_W-1:0] den;
    } t_calc_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_calc_rsp;

endpackage

[rtl/core/eaba_if.sv]
// Handshake channels of the event-aligned block averager: input items,
// result items and configuration writes. Depends on no other file.
`timescale 1ns / 1ps

interface eaba_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [15:0] sample_value;
    logic [15:0]        start_index;

    modport source (output valid, operation, sample_value, start_index, input ready);
    modport sink   (input valid, operation, sample_value, start_index, output ready);
endinterface

interface eaba_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [15:0]        block_number;
    logic signed [6:0]  offset;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, status, block_number, offset, value, last, input ready);
    modport sink   (input valid, status, block_number, offset, value, last, output ready);
endinterface

interface eaba_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [5:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/event_aligned_block_averager.sv]
// Top level of the event-aligned block averager: sample store, block sum
// store, event sequencer and output register. Depends on eaba_pkg, the
// channel interfaces in eaba_if.sv and the arithmetic unit eaba_calc.
//
// Usage. Items arrive on i_in; operation selects load sample, event start or
// emit average. A load is written to the sample store while it has room.
// An event cuts the block around its start index, normalises it and either
// sends one result item per position (output_mode 1) or adds the block into
// the sums. An emit sends the rounded per-position averages and clears the
// sums. Configuration writes on i_cfg are always taken and apply at once.
// An event scans the block, finds the deviation in z-score mode, then
// handles each position in turn, with a division where one is needed, on
// the bit-serial divider that every position shares. An emit divides at
// each position. Skipped blocks give one result. Every result leaves
// through the output register. Reset clears the counters and the sums and
// sets the configuration to its defaults; the sample store keeps its
// contents but only loaded entries are ever read. When the receiver
// stalls, the sequencer holds the next result until the register is free.
`timescale 1ns / 1ps

module event_aligned_block_averager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    eaba_cfg_if.sink    i_cfg,
    eaba_in_if.sink     i_in,
    eaba_out_if.source  o_out
);

    // Configuration registers.
    logic [5:0] r_pre, r_post, r_span, r_excl;
    logic [2:0] r_norm;
    logic       r_omode, r_neg;

    // Counters and control.
    eaba_pkg::t_state r_state, n_state;
    logic [16:0] r_loaded;
    logic [15:0] r_used;
    logic [15:0] r_events;
    logic [63:0] r_sv;
    logic [6:0]  r_ptr;
    logic        r_v1, r_sq_v;
    logic        r_is_emit;

    // Block description.
    logic [15:0] r_base;
    logic [6:0]  r_n2, r_k;
    logic [5:0]  r_lo, r_hi;
    logic [15:0] r_bn;
    logic [1:0]  r_skip_st;

    // Scan accumulators.
    logic [5:0]         r_p1;
    logic [31:0]        r_sq;
    logic signed [22:0] r_ssum, r_bsum;
    logic [36:0]        r_bsq;
    logic signed [15:0] r_s0;

    // Deviation.
    logic [42:0] r_m1, r_m2;
    logic [12:0] r_mkk;
    logic [31:0] r_sdq;
    logic [38:0] r_den3;

    // Per position.
    logic signed [15:0] r_x;
    logic signed [23:0] r_d;
    logic signed [22:0] r_xn;
    logic               r_neg_res;
    logic [57:0]        r_mag;
    logic [39:0]        r_den;
    logic signed [31:0] r_val;

    // Output register.
    logic               r_o_valid;
    logic [1:0]         r_o_status;
    logic [15:0]        r_o_bn;
    logic signed [6:0]  r_o_off;
    logic signed [31:0] r_o_val;
    logic               r_o_last;

    // Memories.
    logic signed [15:0] r_sample_mem [eaba_pkg::MAX_SAMPLES];
    logic signed [15:0] r_sdata;
    logic signed [47:0] r_sum_mem [eaba_pkg::MAX_BLOCK];
    logic signed [47:0] r_sum_rdata;

    eaba_pkg::t_calc_req calc_req;
    eaba_pkg::t_calc_rsp calc_rsp;

    logic        in_acc, cfg_acc, out_free, out_load, p_last;
    logic [6:0]  ev_n2;
    logic [5:0]  ev_pn, ev_px;
    logic        ev_long, ev_early, ev_beyond;
    logic        samp_we;
    logic signed [15:0] load_val;
    logic [15:0] samp_ra;
    logic        in_win;
    logic signed [31:0] sq_prod;
    logic [43:0] m1_full;
    logic signed [45:0] m2_full;
    logic [12:0] mkk_full;
    logic [42:0] var_v;
    logic [38:0] den3_full;
    logic signed [23:0] xk;
    logic signed [22:0] xn_full;
    logic [23:0] abs_d;
    logic [22:0] abs_xn, abs_ssum;
    logic signed [16:0] diff_s0;
    logic signed [32:0] diff_q;
    logic        xn_div;
    logic        xn_neg;
    logic [57:0] xn_mag;
    logic [39:0] xn_den;
    logic signed [31:0] xn_val;
    logic        ovf;
    logic [32:0] q33;
    logic signed [31:0] q_val;
    logic signed [47:0] sum_rd, acc_new;
    logic [47:0] abs_sum;
    logic signed [6:0] pos_off;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    assign in_acc   = i_in.valid && i_in.ready;
    assign cfg_acc  = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_o_valid || o_out.ready;
    assign p_last   = (r_ptr == (r_n2 - 7'd1));

    assign i_in.ready  = (r_state == eaba_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_o_valid;
    assign o_out.status       = r_o_status;
    assign o_out.block_number = r_o_bn;
    assign o_out.offset       = r_o_off;
    assign o_out.value        = r_o_val;
    assign o_out.last         = r_o_last;

    // Block shape and bounds checks for an arriving event or emit.
    always_comb begin
        ev_n2 = {1'b0, r_pre} + {1'b0, r_post} + 7'd1;
        ev_pn = (r_span != 6'd0) ? r_span : r_pre;
        if (ev_pn > r_pre) begin
            ev_pn = r_pre;
        end
        ev_px     = (r_excl > ev_pn) ? ev_pn : r_excl;
        ev_long   = ev_n2 > 7'(eaba_pkg::MAX_BLOCK);
        ev_early  = i_in.start_index < {10'd0, r_pre};
        ev_beyond = ({1'b0, i_in.start_index} + {11'd0, r_post}) >= r_loaded;
    end

    always_comb begin
        if (r_neg) begin
            load_val = (i_in.sample_value == 16'sh8000) ? 16'sh7FFF : -i_in.sample_value;
        end else begin
            load_val = i_in.sample_value;
        end
        samp_we = in_acc && (i_in.operation == eaba_pkg::OP_LOAD)
                  && (r_loaded < 17'(eaba_pkg::MAX_SAMPLES));
        samp_ra = r_base + {10'd0, r_ptr[5:0]};
    end

    always_ff @(posedge i_clk) begin
        if (samp_we) begin
            r_sample_mem[r_loaded[15:0]] <= load_val;
        end
        r_sdata <= r_sample_mem[samp_ra];
    end

    // Sums that were cleared since their last write read as zero.
    always_comb begin
        sum_rd  = r_sv[r_ptr[5:0]] ? r_sum_rdata : 48'sd0;
        acc_new = sum_rd + 48'(r_val);
        abs_sum = sum_rd[47] ? 48'(-sum_rd) : 48'(sum_rd);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == eaba_pkg::S_ACC_WR) begin
            r_sum_mem[r_ptr[5:0]] <= acc_new;
        end
        r_sum_rdata <= r_sum_mem[r_ptr[5:0]];
    end

    // Arithmetic of the scan and per-position stages.
    always_comb begin
        in_win    = (r_p1 >= r_lo) && (r_p1 <= r_hi);
        sq_prod   = r_sdata * r_sdata;
        m1_full   = {7'd0, r_bsq} * {37'd0, r_k};
        m2_full   = r_bsum * r_bsum;
        mkk_full  = {6'd0, r_k} * ({6'd0, r_k} - 13'd1);
        var_v     = r_m1 - r_m2;
        den3_full = {32'd0, r_k} * {7'd0, r_sdq};
        xk        = r_sdata * $signed({1'b0, r_k});
        xn_full   = r_sdata * $signed({1'b0, r_n2});
        abs_d     = r_d[23] ? 24'(-r_d) : 24'(r_d);
        abs_xn    = r_xn[22] ? 23'(-r_xn) : 23'(r_xn);
        abs_ssum  = r_ssum[22] ? 23'(-r_ssum) : 23'(r_ssum);
        diff_s0   = r_x - r_s0;
        diff_q    = {diff_s0, 16'd0};
        pos_off   = $signed({1'b0, r_ptr[5:0]}) - $signed({1'b0, r_pre});
    end

    // Numerator, divisor or direct value of the current position.
    always_comb begin
        xn_div = 1'b0;
        xn_neg = 1'b0;
        xn_mag = '0;
        xn_den = '0;
        xn_val = '0;
        unique case (r_norm)
            eaba_pkg::NORM_MINUS_START: begin
                if (diff_q > 33'sh0_7FFF_FFFF) begin
                    xn_val = VAL_MAX;
                end else if (diff_q < -33'sh0_8000_0000) begin
                    xn_val = VAL_MIN;
                end else begin
                    xn_val = diff_q[31:0];
                end
            end
            eaba_pkg::NORM_BASE_MEAN: begin
                xn_div = 1'b1;
                xn_neg = r_d[23];
                xn_mag = {18'd0, abs_d, 16'd0};
                xn_den = {33'd0, r_k};
            end
            eaba_pkg::NORM_ZSCORE: begin
                if (r_sdq == 32'd0) begin
                    xn_val = r_d[23] ? VAL_MIN : ((r_d != 24'sd0) ? VAL_MAX : 32'sd0);
                end else begin
                    xn_div = 1'b1;
                    xn_neg = r_d[23];
                    xn_mag = {2'd0, abs_d, 32'd0};
                    xn_den = {1'b0, r_den3};
                end
            end
            eaba_pkg::NORM_DIV_MEAN: begin
                if (r_ssum == 23'sd0) begin
                    xn_val = r_x[15] ? VAL_MIN : ((r_x != 16'sd0) ? VAL_MAX : 32'sd0);
                end else begin
                    xn_div = 1'b1;
                    xn_neg = r_xn[22] ^ r_ssum[22];
                    xn_mag = {19'd0, abs_xn, 16'd0};
                    xn_den = {17'd0, abs_ssum};
                end
            end
            default: begin
                xn_val = {r_x, 16'd0};
            end
        endcase
    end

    // Quotient to saturated signed value.
    always_comb begin
        ovf = {15'd0, r_mag[57:33]} >= r_den;
        q33 = calc_rsp.result[32:0];
        if (!r_neg_res) begin
            q_val = (q33[32:31] != 2'b00) ? VAL_MAX : $signed({1'b0, q33[30:0]});
        end else begin
            q_val = (q33 > 33'h0_8000_0000) ? VAL_MIN : $signed(-q33[31:0]);
        end
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        calc_req = '0;
        unique case (r_state)
            eaba_pkg::S_IDLE: begin
                if (in_acc && (i_in.operation == eaba_pkg::OP_EVENT)) begin
                    if (ev_long || ev_early || ev_beyond) begin
                        n_state = eaba_pkg::S_SKIP;
                    end else if (!r_omode && (r_used == 16'hFFFF)) begin
                        n_state = eaba_pkg::S_IDLE;
                    end else begin
                        n_state = eaba_pkg::S_SCAN;
                    end
                end else if (in_acc && (i_in.operation == eaba_pkg::OP_EMIT)) begin
                    if ((r_used == 16'd0) || ev_long) begin
                        n_state = eaba_pkg::S_SKIP;
                    end else begin
                        n_state = eaba_pkg::S_EM_RD;
                    end
                end
            end
            eaba_pkg::S_SKIP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = eaba_pkg::S_IDLE;
                end
            end
            eaba_pkg::S_SCAN: begin
                if ((r_ptr == r_n2) && !r_v1 && !r_sq_v) begin
                    n_state = (r_norm == eaba_pkg::NORM_ZSCORE) ? eaba_pkg::S_VAR1
                                                               : eaba_pkg::S_XRD;
                end
            end
            eaba_pkg::S_VAR1: n_state = eaba_pkg::S_VAR2;
            eaba_pkg::S_VAR2: begin
                if (r_k == 7'd1) begin
                    n_state = eaba_pkg::S_DEN;
                end else begin
                    calc_req.start = 1'b1;
                    calc_req.op    = eaba_pkg::CALC_DIV_LONG;
                    calc_req.num   = {1'b0, var_v, 32'd0};
                    calc_req.den   = {27'd0, r_mkk};
                    n_state        = eaba_pkg::S_VDIV;
                end
            end
            eaba_pkg::S_VDIV: begin
                if (calc_rsp.done) begin
                    calc_req.start = 1'b1;
                    calc_req.op    = eaba_pkg::CALC_SQRT;
                    calc_req.num   = {12'd0, calc_rsp.result};
                    n_state        = eaba_pkg::S_SQRT;
                end
            end
            eaba_pkg::S_SQRT: begin
                if (calc_rsp.done) begin
                    n_state = eaba_pkg::S_DEN;
                end
            end
            eaba_pkg::S_DEN:   n_state = eaba_pkg::S_XRD;
            eaba_pkg::S_XRD:   n_state = eaba_pkg::S_XWAIT;
            eaba_pkg::S_XWAIT: n_state = eaba_pkg::S_XNUM;
            eaba_pkg::S_XNUM:  n_state = xn_div ? eaba_pkg::S_DPREP : eaba_pkg::S_PUT;
            eaba_pkg::S_DPREP: n_state = eaba_pkg::S_DCHK;
            eaba_pkg::S_DCHK: begin
                if (ovf) begin
                    n_state = eaba_pkg::S_PUT;
                end else begin
                    calc_req.start = 1'b1;
                    calc_req.op    = eaba_pkg::CALC_DIV_SHORT;
                    calc_req.num   = {18'd0, r_mag};
                    calc_req.den   = r_den;
                    n_state        = eaba_pkg::S_DWAIT;
                end
            end
            eaba_pkg::S_DWAIT: begin
                if (calc_rsp.done) begin
                    n_state = eaba_pkg::S_PUT;
                end
            end
            eaba_pkg::S_PUT: begin
                n_state = (r_is_emit || r_omode) ? eaba_pkg::S_OUT : eaba_pkg::S_ACC_WR;
            end
            eaba_pkg::S_ACC_WR: begin
                n_state = p_last ? eaba_pkg::S_IDLE : eaba_pkg::S_XRD;
            end
            eaba_pkg::S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (p_last) begin
                        n_state = eaba_pkg::S_IDLE;
                    end else begin
                        n_state = r_is_emit ? eaba_pkg::S_EM_RD : eaba_pkg::S_XRD;
                    end
                end
            end
            eaba_pkg::S_EM_RD:   n_state = eaba_pkg::S_EM_WAIT;
            eaba_pkg::S_EM_WAIT: n_state = eaba_pkg::S_DPREP;
            default:             n_state = eaba_pkg::S_IDLE;
        endcase
    end

    eaba_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (calc_req),
        .o_rsp   (calc_rsp)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= eaba_pkg::S_IDLE;
            r_pre     <= 6'd0;
            r_post    <= 6'd10;
            r_span    <= 6'd0;
            r_excl    <= 6'd0;
            r_norm    <= eaba_pkg::NORM_NONE;
            r_omode   <= 1'b0;
            r_neg     <= 1'b0;
            r_loaded  <= '0;
            r_used    <= '0;
            r_events  <= '0;
            r_sv      <= '0;
            r_ptr     <= '0;
            r_v1      <= 1'b0;
            r_sq_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_acc) begin
                unique case (i_cfg.index)
                    eaba_pkg::REG_PRE_COUNT:        r_pre   <= i_cfg.data;
                    eaba_pkg::REG_POST_COUNT:       r_post  <= i_cfg.data;
                    eaba_pkg::REG_BASELINE_SPAN:    r_span  <= i_cfg.data;
                    eaba_pkg::REG_BASELINE_EXCLUDE: r_excl  <= i_cfg.data;
                    eaba_pkg::REG_NORM_MODE:        r_norm  <= i_cfg.data[2:0];
                    eaba_pkg::REG_OUTPUT_MODE:      r_omode <= i_cfg.data[0];
                    eaba_pkg::REG_NEGATE_INPUT:     r_neg   <= i_cfg.data[0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end

            r_v1   <= (r_state == eaba_pkg::S_SCAN) && (r_ptr < r_n2);
            r_sq_v <= r_v1 && in_win;

            if (samp_we) begin
                r_loaded <= r_loaded + 17'd1;
            end

            unique case (r_state)
                eaba_pkg::S_IDLE: begin
                    if (in_acc && (i_in.operation == eaba_pkg::OP_EVENT)) begin
                        r_events <= r_events + 16'd1;
                        r_ptr    <= '0;
                    end else if (in_acc && (i_in.operation == eaba_pkg::OP_EMIT)) begin
                        r_ptr <= '0;
                        if ((r_used == 16'd0) || ev_long) begin
                            r_sv   <= '0;
                            r_used <= '0;
                        end
                    end
                end
                eaba_pkg::S_SCAN: begin
                    if (n_state != eaba_pkg::S_SCAN) begin
                        r_ptr <= '0;
                    end else if (r_ptr < r_n2) begin
                        r_ptr <= r_ptr + 7'd1;
                    end
                end
                eaba_pkg::S_ACC_WR: begin
                    r_sv[r_ptr[5:0]] <= 1'b1;
                    if (p_last) begin
                        r_used <= r_used + 16'd1;
                    end else begin
                        r_ptr <= r_ptr + 7'd1;
                    end
                end
                eaba_pkg::S_OUT: begin
                    if (out_free) begin
                        if (!p_last) begin
                            r_ptr <= r_ptr + 7'd1;
                        end else if (r_is_emit) begin
                            r_sv   <= '0;
                            r_used <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc && (r_state == eaba_pkg::S_IDLE)) begin
            r_n2   <= ev_n2;
            r_k    <= {1'b0, ev_pn - ev_px} + 7'd1;
            r_lo   <= r_pre - ev_pn;
            r_hi   <= r_pre - ev_px;
            r_base <= i_in.start_index - {10'd0, r_pre};
            r_ssum <= '0;
            r_bsum <= '0;
            r_bsq  <= '0;
            if (i_in.operation == eaba_pkg::OP_EMIT) begin
                r_is_emit <= 1'b1;
                r_bn      <= '0;
                r_skip_st <= eaba_pkg::ST_NO_BLOCKS;
            end else begin
                r_is_emit <= 1'b0;
                r_bn      <= r_events;
                if (ev_long) begin
                    r_skip_st <= eaba_pkg::ST_NO_BLOCKS;
                end else if (ev_early) begin
                    r_skip_st <= eaba_pkg::ST_EARLY;
                end else begin
                    r_skip_st <= eaba_pkg::ST_BEYOND;
                end
            end
        end

        // Scan pipeline: read, then accumulate and square, then sum squares.
        r_p1 <= r_ptr[5:0];
        if (r_v1) begin
            r_ssum <= r_ssum + 23'(r_sdata);
            if (in_win) begin
                r_bsum <= r_bsum + 23'(r_sdata);
            end
            if (r_p1 == r_pre) begin
                r_s0 <= r_sdata;
            end
        end
        r_sq <= sq_prod;
        if (r_sq_v) begin
            r_bsq <= r_bsq + {5'd0, r_sq};
        end

        unique case (r_state)
            eaba_pkg::S_VAR1: begin
                r_m1  <= m1_full[42:0];
                r_m2  <= m2_full[42:0];
                r_mkk <= mkk_full;
            end
            eaba_pkg::S_VAR2: begin
                if (r_k == 7'd1) begin
                    r_sdq <= eaba_pkg::SD_ONE_POINT_ONE;
                end
            end
            eaba_pkg::S_SQRT: begin
                if (calc_rsp.done) begin
                    r_sdq <= calc_rsp.result[31:0];
                end
            end
            eaba_pkg::S_DEN: begin
                r_den3 <= den3_full;
            end
            eaba_pkg::S_XWAIT: begin
                r_x  <= r_sdata;
                r_d  <= xk - 24'(r_bsum);
                r_xn <= xn_full;
            end
            eaba_pkg::S_XNUM: begin
                r_neg_res <= xn_neg;
                r_mag     <= xn_mag;
                r_den     <= xn_den;
                r_val     <= xn_val;
            end
            eaba_pkg::S_EM_WAIT: begin
                r_neg_res <= sum_rd[47];
                r_mag     <= {10'd0, abs_sum};
                r_den     <= {24'd0, r_used};
            end
            eaba_pkg::S_DPREP: begin
                // Round to nearest, ties away from zero, on the magnitude.
                r_mag <= r_mag + {19'd0, r_den[39:1]};
            end
            eaba_pkg::S_DCHK: begin
                if (ovf) begin
                    r_val <= r_neg_res ? VAL_MIN : VAL_MAX;
                end
            end
            eaba_pkg::S_DWAIT: begin
                if (calc_rsp.done) begin
                    r_val <= q_val;
                end
            end
            default: ;
        endcase

        if (out_load) begin
            if (r_state == eaba_pkg::S_SKIP) begin
                r_o_status <= r_skip_st;
                r_o_bn     <= r_bn;
                r_o_off    <= '0;
                r_o_val    <= '0;
                r_o_last   <= 1'b1;
            end else begin
                r_o_status <= eaba_pkg::ST_VALUE;
                r_o_bn     <= r_bn;
                r_o_off    <= pos_off;
                r_o_val    <= r_val;
                r_o_last   <= p_last;
            end
        end
    end

endmodule

[rtl/core/eaba_calc.sv]
// Shared sequential arithmetic unit: restoring division one quotient bit a
// cycle (64 or 33 bits) and integer square root one root bit a cycle.
// Depends on eaba_pkg.
`timescale 1ns / 1ps

module eaba_calc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  eaba_pkg::t_calc_req i_req,
    output eaba_pkg::t_calc_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [6:0]           r_cnt;
    eaba_pkg::t_calc_op   r_op;
    logic [40:0]          r_rem;
    logic [63:0]          r_sh;
    logic [63:0]          r_q;
    logic [39:0]          r_den;

    logic [40:0] div_t;
    logic        div_ge;
    logic [35:0] sq_t;
    logic [35:0] sq_trial;
    logic        sq_ge;

    always_comb begin
        div_t    = {r_rem[39:0], r_sh[63]};
        div_ge   = div_t >= {1'b0, r_den};
        sq_t     = {r_rem[33:0], r_sh[63:62]};
        sq_trial = {2'b00, r_q[31:0], 2'b01};
        sq_ge    = sq_t >= sq_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                unique case (i_req.op)
                    eaba_pkg::CALC_DIV_LONG:  r_cnt <= 7'd64;
                    eaba_pkg::CALC_DIV_SHORT: r_cnt <= 7'd33;
                    eaba_pkg::CALC_SQRT:      r_cnt <= 7'd32;
                    default:                  r_cnt <= 7'd32;
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_op  <= i_req.op;
            r_den <= i_req.den;
            r_q   <= '0;
            unique case (i_req.op)
                eaba_pkg::CALC_DIV_LONG: begin
                    r_rem <= {29'd0, i_req.num[75:64]};
                    r_sh  <= i_req.num[63:0];
                end
                eaba_pkg::CALC_DIV_SHORT: begin
                    // The caller guarantees that the high part is below the divisor.
                    r_rem <= {1'b0, i_req.num[72:33]};
                    r_sh  <= {i_req.num[32:0], 31'd0};
                end
                default: begin
                    r_rem <= '0;
                    r_sh  <= i_req.num[63:0];
                end
            endcase
        end else if (r_busy) begin
            if (r_op == eaba_pkg::CALC_SQRT) begin
                r_sh <= {r_sh[61:0], 2'b00};
                if (sq_ge) begin
                    r_rem <= {5'd0, sq_t - sq_trial};
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= {5'd0, sq_t};
                    r_q   <= {r_q[62:0], 1'b0};
                end
            end else begin
                r_sh <= {r_sh[62:0], 1'b0};
                if (div_ge) begin
                    r_rem <= div_t - {1'b0, r_den};
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= div_t;
                    r_q   <= {r_q[62:0], 1'b0};
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_q;

endmodule
